// ----- hw/rtl/utc_pkg.sv -----
package utc_pkg;

    // Largest number of units that a buffer may hold.
    localparam logic [10:0] MAX_UNITS = 11'd256;

    // Flag bits of the result word.
    localparam logic [15:0] FLAG_ASCII16        = 16'h0001;
    localparam logic [15:0] FLAG_STATISTICS     = 16'h0002;
    localparam logic [15:0] FLAG_CONTROLS       = 16'h0004;
    localparam logic [15:0] FLAG_SIGNATURE      = 16'h0008;
    localparam logic [15:0] FLAG_REV_ASCII16    = 16'h0010;
    localparam logic [15:0] FLAG_REV_STATISTICS = 16'h0020;
    localparam logic [15:0] FLAG_REV_CONTROLS   = 16'h0040;
    localparam logic [15:0] FLAG_REV_SIGNATURE  = 16'h0080;
    localparam logic [15:0] FLAG_ILLEGAL_CHARS  = 16'h0100;
    localparam logic [15:0] FLAG_ODD_LENGTH     = 16'h0200;
    localparam logic [15:0] FLAG_NULL_BYTES     = 16'h1000;

    // Flags reported when a buffer is rejected before any test runs.
    localparam logic [15:0] FLAGS_EARLY_REJECT  = 16'h0005;

    // Groups of flags used by the verdict.
    localparam logic [15:0] VERDICT_SIG_GROUP   = 16'h0B08;
    localparam logic [15:0] VERDICT_REV_GROUP   = 16'h00F0;
    localparam logic [15:0] VERDICT_BAD_GROUP   = 16'h0F00;
    localparam logic [15:0] VERDICT_GOOD_GROUP  = 16'hF00F;

    // Special code units.
    localparam logic [15:0] UNIT_BOM            = 16'hFEFF;
    localparam logic [15:0] UNIT_BOM_SWAPPED    = 16'hFFFE;
    localparam logic [15:0] UNIT_IDEO_SPACE     = 16'h3000;
    localparam logic [15:0] UNIT_CRLF_PACKED    = 16'h0A0D;
    localparam logic [7:0]  BYTE_CR             = 8'h0D;
    localparam logic [7:0]  BYTE_LF             = 8'h0A;
    localparam logic [7:0]  BYTE_EOF            = 8'h1A;
    localparam logic [15:0] LOW_VAR_LIMIT       = 16'h007F;
    localparam logic [9:0]  LENGTH_CAP          = 10'd512;

    // Signature codes taken from the first unit of a buffer.
    localparam logic [1:0]  SIG_NONE            = 2'b00;
    localparam logic [1:0]  SIG_BOM             = 2'b01;
    localparam logic [1:0]  SIG_BOM_SWAPPED     = 2'b10;

    typedef struct packed {
        logic        saw_control;
        logic        saw_reverse_control;
        logic        saw_illegal;
        logic [8:0]  crlf_count;
        logic [9:0]  zero_byte_count;
        logic [15:0] high_variation;
        logic [15:0] low_variation;
        logic [7:0]  previous_high;
        logic [7:0]  previous_low;
        logic [1:0]  signature_bits;
        logic        first_pending;
    } stat_t;

    localparam stat_t STAT_RESET = '{
        saw_control:         1'b0,
        saw_reverse_control: 1'b0,
        saw_illegal:         1'b0,
        crlf_count:          9'd0,
        zero_byte_count:     10'd0,
        high_variation:      16'd0,
        low_variation:       16'd0,
        previous_high:       8'd0,
        previous_low:        8'd0,
        signature_bits:      SIG_NONE,
        first_pending:       1'b1
    };

    function automatic logic is_crlf(input logic [7:0] lo, input logic [7:0] hi_prev);
        return ((lo == BYTE_CR) && (hi_prev == BYTE_LF)) ||
               ((lo == BYTE_LF) && (hi_prev == BYTE_CR));
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [8:0] crlf_inc(input logic [8:0] c);
        return (c == 9'h1FF) ? c : c + 9'd1;
    endfunction

endpackage

// ----- hw/rtl/utf16_text_classifier.sv -----
// UTF-16 text classifier.
// The input channel (s_valid / s_ready) carries one little-endian 16-bit code
// unit per word, with the buffer's byte length, an optional test mask and a
// flag that marks the last unit of the buffer. Words that are not last give
// no result; the last word gives one result word on the output channel
// (m_valid / m_ready) holding the test flags and the is_unicode verdict.
// The block takes one input word per clock cycle while no last word waits
// for room in the output register. A word is held in an input register
// while the scan logic updates the running statistics; the result of a
// last word is loaded into the output register once it is free, raising
// m_valid. The output register separates the two sides: while a result
// waits, words that are not last keep flowing, and only a further last word
// waits in the input register until the result has been taken.
// A synchronous active-low reset on aresetn empties both registers and puts
// the statistics in their start-of-buffer state. After each last word the
// statistics return to that state, so buffers can follow each other directly.
module utf16_text_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_unit,
    input  logic        s_last_unit,
    input  logic [9:0]  s_buffer_length,
    input  logic        s_mask_given,
    input  logic [15:0] s_mask_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_flags_out,
    output logic        m_is_unicode
);
    import utc_pkg::*;

    // Input register: valid bit with reset, payload without.
    logic        in_valid_reg, in_valid_next;
    logic [15:0] in_unit_reg;
    logic        in_last_reg;
    logic [9:0]  in_len_reg;
    logic        in_mask_given_reg;
    logic [15:0] in_mask_reg;

    // Running statistics of the current buffer.
    stat_t       stat_reg, stat_next;
    stat_t       stat_scanned;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_flags_reg;
    logic        out_unicode_reg;

    logic        out_free;
    logic        proc_go;
    logic        s_take;
    logic        len_ok;
    logic        early_reject;
    logic        drop_last;
    logic        do_scan;
    logic [15:0] verdict_flags;
    logic        verdict_unicode;

    // The output register can take a result when it is empty or being read.
    assign out_free = !out_valid_reg || m_ready;
    // A word that is not last never waits; a last word needs room for its result.
    assign proc_go  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || proc_go;
    assign s_take   = s_valid && s_ready;

    assign len_ok       = (in_len_reg >= 10'd2);
    // Buffers shorter than two bytes, or a single unit that looks like ASCII.
    assign early_reject = !len_ok ||
                          ((in_len_reg == 10'd2) && (in_unit_reg != 16'd0) &&
                           (in_unit_reg[15:8] == 8'd0));
    // For even lengths that fit, a trailing unit with a zero high byte is
    // not counted.
    assign drop_last    = (in_len_reg > 10'd2) && !in_len_reg[0] &&
                          ({2'b0, in_len_reg[9:1]} <= MAX_UNITS) &&
                          (in_unit_reg[15:8] == 8'd0);
    assign do_scan      = len_ok && !(in_last_reg && drop_last);

    utc_scan u_scan (
        .stat_in  (stat_reg),
        .unit     (in_unit_reg),
        .do_sig   (len_ok),
        .do_scan  (do_scan),
        .stat_out (stat_scanned)
    );

    utc_verdict u_verdict (
        .stat_in       (stat_scanned),
        .buffer_length (in_len_reg),
        .early_reject  (early_reject),
        .mask_given    (in_mask_given_reg),
        .mask_in       (in_mask_reg),
        .flags_out     (verdict_flags),
        .is_unicode    (verdict_unicode)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (proc_go) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        stat_next = stat_reg;
        if (proc_go) begin
            stat_next = in_last_reg ? STAT_RESET : stat_scanned;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (proc_go && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stat_reg      <= STAT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            stat_reg      <= stat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_unit_reg       <= s_unit;
            in_last_reg       <= s_last_unit;
            in_len_reg        <= s_buffer_length;
            in_mask_given_reg <= s_mask_given;
            in_mask_reg       <= s_mask_in;
        end
        if (proc_go && in_last_reg) begin
            out_flags_reg   <= verdict_flags;
            out_unicode_reg <= verdict_unicode;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_flags_out  = out_flags_reg;
    assign m_is_unicode = out_unicode_reg;

endmodule

// ----- hw/rtl/utc_scan.sv -----
module utc_scan (
    input  utc_pkg::stat_t stat_in,
    input  logic [15:0]    unit,
    input  logic           do_sig,
    input  logic           do_scan,
    output utc_pkg::stat_t stat_out
);
    import utc_pkg::*;

    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [10:0] zero_sum;
    logic [16:0] high_sum;
    logic [16:0] low_sum;
    logic [1:0]  zero_add;

    assign lo       = unit[7:0];
    assign hi       = unit[15:8];
    assign zero_add = {1'b0, (lo == 8'd0)} + {1'b0, (hi == 8'd0)};
    assign zero_sum = {1'b0, stat_in.zero_byte_count} + {9'd0, zero_add};
    assign high_sum = {1'b0, stat_in.high_variation}
                    + {9'd0, abs_diff(hi, stat_in.previous_high)};
    assign low_sum  = {1'b0, stat_in.low_variation}
                    + {9'd0, abs_diff(lo, stat_in.previous_low)};

    always_comb begin
        stat_out = stat_in;
        // The signature comes from the first unit of the buffer, scanned or not.
        if (do_sig && stat_in.first_pending) begin
            stat_out.first_pending = 1'b0;
            if (unit == UNIT_BOM) begin
                stat_out.signature_bits = SIG_BOM;
            end else if (unit == UNIT_BOM_SWAPPED) begin
                stat_out.signature_bits = SIG_BOM_SWAPPED;
            end else begin
                stat_out.signature_bits = SIG_NONE;
            end
        end
        if (do_scan) begin
            if (unit == 16'h0020 || unit == 16'h0009 || unit == 16'h000A ||
                unit == 16'h000D || unit == UNIT_IDEO_SPACE) begin
                stat_out.saw_control = 1'b1;
            end
            if (unit == 16'h0900 || unit == 16'h0A00 || unit == 16'h0D00 ||
                unit == 16'h2000) begin
                stat_out.saw_reverse_control = 1'b1;
            end
            if (unit == 16'h0000 || unit == UNIT_CRLF_PACKED ||
                unit == UNIT_BOM_SWAPPED || unit == 16'hFFFF) begin
                stat_out.saw_illegal = 1'b1;
            end
            if (is_crlf(lo, stat_in.previous_high)) begin
                stat_out.crlf_count = crlf_inc(stat_in.crlf_count);
            end
            stat_out.zero_byte_count = zero_sum[10] ? 10'h3FF : zero_sum[9:0];
            stat_out.high_variation  = high_sum[16] ? 16'hFFFF : high_sum[15:0];
            stat_out.low_variation   = low_sum[16] ? 16'hFFFF : low_sum[15:0];
            stat_out.previous_high   = hi;
            stat_out.previous_low    = lo;
        end
    end

endmodule

// ----- hw/rtl/utc_verdict.sv -----
module utc_verdict (
    input  utc_pkg::stat_t stat_in,
    input  logic [9:0]     buffer_length,
    input  logic           early_reject,
    input  logic           mask_given,
    input  logic [15:0]    mask_in,
    output logic [15:0]    flags_out,
    output logic           is_unicode
);
    import utc_pkg::*;

    logic [8:0]  crlf_a;
    logic [8:0]  crlf;
    logic [9:0]  zc;
    logic [9:0]  cap;
    logic [15:0] crlf_x40;
    logic        crlf_hit;
    logic [17:0] high_x3;
    logic [17:0] low_x3;
    logic [15:0] f;
    logic [15:0] fm;

    assign crlf_a = is_crlf(stat_in.previous_low, stat_in.previous_high)
                  ? crlf_inc(stat_in.crlf_count) : stat_in.crlf_count;
    assign crlf   = (stat_in.previous_high == BYTE_EOF) ? crlf_inc(crlf_a) : crlf_a;
    assign zc     = (stat_in.previous_high != 8'd0) ? stat_in.zero_byte_count
                                                    : stat_in.zero_byte_count - 10'd1;
    assign cap    = (buffer_length > LENGTH_CAP) ? LENGTH_CAP : buffer_length;

    // crlf >= cap/40 is the same as cap < 40 * (crlf + 1).
    assign crlf_x40 = {2'b0, crlf, 5'd0} + {4'd0, crlf, 3'd0} + 16'd40;
    assign crlf_hit = (crlf != 9'd0) && ({6'd0, cap} < crlf_x40);

    assign high_x3 = {1'b0, stat_in.high_variation, 1'b0} + {2'b0, stat_in.high_variation};
    assign low_x3  = {1'b0, stat_in.low_variation, 1'b0} + {2'b0, stat_in.low_variation};

    always_comb begin
        f = 16'd0;
        if (stat_in.low_variation < LOW_VAR_LIMIT) begin
            if (stat_in.high_variation == 16'd0) begin
                f = FLAG_ASCII16;
            end else if (stat_in.low_variation == 16'd0) begin
                f = FLAG_REV_ASCII16;
            end
        end
        if (high_x3 < {2'b0, stat_in.low_variation}) f |= FLAG_STATISTICS;
        if (low_x3 < {2'b0, stat_in.high_variation}) f |= FLAG_REV_STATISTICS;
        if (stat_in.saw_control) f |= FLAG_CONTROLS;
        if (stat_in.saw_reverse_control) f |= FLAG_REV_CONTROLS;
        if (stat_in.saw_illegal || crlf_hit) f |= FLAG_ILLEGAL_CHARS;
        if (buffer_length[0]) f |= FLAG_ODD_LENGTH;
        if (zc != 10'd0) f |= FLAG_NULL_BYTES;
        if (stat_in.signature_bits[0]) begin
            f |= FLAG_SIGNATURE;
        end else if (stat_in.signature_bits[1]) begin
            f |= FLAG_REV_SIGNATURE;
        end
    end

    assign fm = mask_given ? (f & mask_in) : f;

    always_comb begin
        if (early_reject) begin
            flags_out  = FLAGS_EARLY_REJECT;
            is_unicode = 1'b0;
        end else begin
            flags_out = fm;
            if ((fm & VERDICT_SIG_GROUP) == FLAG_SIGNATURE) begin
                is_unicode = 1'b1;
            end else if ((fm & VERDICT_REV_GROUP) != 16'd0) begin
                is_unicode = 1'b0;
            end else if ((fm & VERDICT_BAD_GROUP) != 16'd0) begin
                is_unicode = 1'b0;
            end else begin
                is_unicode = ((fm & VERDICT_GOOD_GROUP) != 16'd0);
            end
        end
    end

endmodule

// ----- hw/rtl/utc_checker.sv -----
module utc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_flags_out,
    input  logic        m_is_unicode
);
    import utc_pkg::*;

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_flags_out) && $stable(m_is_unicode))
        else $error("result word changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // A forward signature alone means UTF-16 text.
    a_sig_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_flags_out & VERDICT_SIG_GROUP) == FLAG_SIGNATURE) |-> m_is_unicode)
        else $error("signature flag without a positive verdict");

    // Reverse or illegal flags without the signature case mean not text.
    a_bad_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_flags_out & VERDICT_SIG_GROUP) != FLAG_SIGNATURE) &&
        (((m_flags_out & VERDICT_REV_GROUP) != 16'd0) ||
         ((m_flags_out & VERDICT_BAD_GROUP) != 16'd0)) |-> !m_is_unicode)
        else $error("reverse or illegal flags with a positive verdict");

endmodule

bind utf16_text_classifier utc_checker u_utc_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import utc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int WORD_TARGET = 850;
    localparam int IDLE_PERCENT = 16;
    localparam int SETTLE_CYCLES = 20;

    // Words between these counts go out with neither side idling.
    localparam int STEADY_FROM = 250;
    localparam int STEADY_TO = 450;

    // Kinds of text that the random buffers are made of.
    typedef enum int {
        TEXT_ASCII,
        TEXT_SWAPPED,
        TEXT_WIDE,
        TEXT_RANDOM,
        TEXT_SPECIAL,
        TEXT_MIXED,
        TEXT_NOISE
    } text_kind_e;

    // One word of the input channel, plus a request to let the block drain first.
    typedef struct packed {
        logic [15:0] unit;
        logic        last;
        logic [9:0]  len;
        logic        mgiven;
        logic [15:0] mask;
        logic        drain;
    } unit_word_t;

    typedef struct packed {
        logic [15:0] flags;
        logic        is_text;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_unit = '0;
    logic        s_last_unit = 1'b0;
    logic [9:0]  s_buffer_length = '0;
    logic        s_mask_given = 1'b0;
    logic [15:0] s_mask_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_flags_out;
    logic        m_is_unicode;

    unit_word_t words_to_send[$];
    verdict_t   pending_verdicts[$];
    unit_word_t on_wire;

    int  words_sent = 0;
    int  verdicts_checked = 0;
    int  early_rejects = 0;
    int  judged_text = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    logic steady = 1'b0;

    // Running statistics of the buffer being scanned.
    logic        seen_ctrl;
    logic        seen_rev_ctrl;
    logic        seen_illegal;
    logic [8:0]  pair_count;
    logic [9:0]  zero_count;
    logic [15:0] hi_swing;
    logic [15:0] lo_swing;
    logic [7:0]  prior_hi;
    logic [7:0]  prior_lo;
    logic [1:0]  sig_code;
    logic        sig_open;

    utf16_text_classifier DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_unit         (s_unit),
        .s_last_unit    (s_last_unit),
        .s_buffer_length(s_buffer_length),
        .s_mask_given   (s_mask_given),
        .s_mask_in      (s_mask_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_flags_out    (m_flags_out),
        .m_is_unicode   (m_is_unicode)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Prediction of the flags and the verdict.
    // ---------------------------------------------------------------------

    task automatic clear_stats();
        seen_ctrl = 1'b0;
        seen_rev_ctrl = 1'b0;
        seen_illegal = 1'b0;
        pair_count = '0;
        zero_count = '0;
        hi_swing = '0;
        lo_swing = '0;
        prior_hi = '0;
        prior_lo = '0;
        sig_code = SIG_NONE;
        sig_open = 1'b1;
    endtask

    // A CR and an LF, in either order, split across a unit boundary (or inside
    // the final unit, when the caller passes its own two bytes).
    function automatic logic line_break_pair(input logic [7:0] lo, input logic [7:0] hi_before);
        return (lo == BYTE_CR && hi_before == BYTE_LF) || (lo == BYTE_LF && hi_before == BYTE_CR);
    endfunction

    function automatic int capped_sum(input int a, input int b, input int top);
        return (a + b > top) ? top : a + b;
    endfunction

    function automatic int byte_distance(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // The signature comes from the first unit that reaches the block for a
    // buffer, whether or not that unit is scanned afterwards.
    task automatic note_signature(input logic [15:0] u);
        if (sig_open) begin
            if (u == UNIT_BOM) sig_code = SIG_BOM;
            else if (u == UNIT_BOM_SWAPPED) sig_code = SIG_BOM_SWAPPED;
            else sig_code = SIG_NONE;
            sig_open = 1'b0;
        end
    endtask

    task automatic scan_unit(input logic [15:0] u);
        logic [7:0] lo;
        logic [7:0] hi;
        int zeros;
        lo = u[7:0];
        hi = u[15:8];
        if (u == 16'h0020 || u == 16'h0009 || u == 16'h000A || u == 16'h000D ||
            u == UNIT_IDEO_SPACE)
            seen_ctrl = 1'b1;
        if (u == 16'h0900 || u == 16'h0A00 || u == 16'h0D00 || u == 16'h2000)
            seen_rev_ctrl = 1'b1;
        if (u == 16'h0000 || u == UNIT_CRLF_PACKED || u == UNIT_BOM_SWAPPED || u == 16'hFFFF)
            seen_illegal = 1'b1;
        if (line_break_pair(lo, prior_hi))
            pair_count = 9'(capped_sum(int'(pair_count), 1, 511));
        zeros = (lo == 8'h00 ? 1 : 0) + (hi == 8'h00 ? 1 : 0);
        zero_count = 10'(capped_sum(int'(zero_count), zeros, 1023));
        hi_swing = 16'(capped_sum(int'(hi_swing), byte_distance(hi, prior_hi), 65535));
        lo_swing = 16'(capped_sum(int'(lo_swing), byte_distance(lo, prior_lo), 65535));
        prior_hi = hi;
        prior_lo = lo;
    endtask

    // Called for every word that the block accepts. A last word closes the
    // buffer and queues the result the block has to give for it.
    task automatic predict(input unit_word_t w);
        verdict_t v;
        logic     drop_tail;
        logic [15:0] f;
        int pairs;
        int zc;
        int cap;
        if (!w.last) begin
            if (w.len >= 2) begin
                note_signature(w.unit);
                scan_unit(w.unit);
            end
            return;
        end

        // Too short to judge, or one unit that reads as plain ASCII.
        if (w.len < 2 || (w.len == 2 && w.unit != 16'h0000 && w.unit[15:8] == 8'h00)) begin
            v.flags = FLAGS_EARLY_REJECT;
            v.is_text = 1'b0;
            pending_verdicts.push_back(v);
            early_rejects++;
            clear_stats();
            return;
        end

        // An even buffer that fits ends in a unit whose high byte is zero: that
        // unit is taken as a stray terminator and left out of the statistics.
        drop_tail = w.len > 2 && !w.len[0] && int'(w.len >> 1) <= int'(MAX_UNITS) &&
                    w.unit[15:8] == 8'h00;
        note_signature(w.unit);
        if (!drop_tail)
            scan_unit(w.unit);

        pairs = int'(pair_count);
        if (line_break_pair(prior_lo, prior_hi))
            pairs = capped_sum(pairs, 1, 511);
        if (prior_hi != 8'h00) begin
            zc = int'(zero_count);
            if (prior_hi == BYTE_EOF)
                pairs = capped_sum(pairs, 1, 511);
        end else begin
            // The trailing zero byte is not counted; with nothing scanned the
            // count wraps and still reads as nonzero.
            zc = (int'(zero_count) - 1) & 10'h3FF;
        end
        cap = (w.len > LENGTH_CAP) ? int'(LENGTH_CAP) : int'(w.len);

        f = '0;
        if (lo_swing < LOW_VAR_LIMIT) begin
            if (hi_swing == 16'd0) f = FLAG_ASCII16;
            else if (lo_swing == 16'd0) f = FLAG_REV_ASCII16;
        end
        if (3 * int'(hi_swing) < int'(lo_swing)) f |= FLAG_STATISTICS;
        if (3 * int'(lo_swing) < int'(hi_swing)) f |= FLAG_REV_STATISTICS;
        if (seen_ctrl) f |= FLAG_CONTROLS;
        if (seen_rev_ctrl) f |= FLAG_REV_CONTROLS;
        if (seen_illegal || (pairs != 0 && pairs >= cap / 40)) f |= FLAG_ILLEGAL_CHARS;
        if (w.len[0]) f |= FLAG_ODD_LENGTH;
        if (zc != 0) f |= FLAG_NULL_BYTES;
        if (sig_code == SIG_BOM) f |= FLAG_SIGNATURE;
        else if (sig_code == SIG_BOM_SWAPPED) f |= FLAG_REV_SIGNATURE;
        if (w.mgiven) f &= w.mask;

        v.flags = f;
        if ((f & VERDICT_SIG_GROUP) == FLAG_SIGNATURE) v.is_text = 1'b1;
        else if ((f & VERDICT_REV_GROUP) != 0) v.is_text = 1'b0;
        else if ((f & VERDICT_BAD_GROUP) != 0) v.is_text = 1'b0;
        else if ((f & VERDICT_GOOD_GROUP) != 0) v.is_text = 1'b1;
        else v.is_text = 1'b0;
        pending_verdicts.push_back(v);
        if (v.is_text) judged_text++;
        clear_stats();
    endtask

    // ---------------------------------------------------------------------
    // Stimulus.
    // ---------------------------------------------------------------------

    task automatic push_word(input logic [15:0] u, input logic last, input int len,
                             input logic mgiven, input logic [15:0] mask, input logic drain);
        unit_word_t w;
        w.unit = u;
        w.last = last;
        w.len = len[9:0];
        w.mgiven = mgiven;
        w.mask = mask;
        w.drain = drain;
        words_to_send.push_back(w);
    endtask

    // Printable characters with a good share of white space and line breaks.
    function automatic logic [7:0] text_byte();
        case ($urandom_range(9))
            0: return 8'h20;
            1: return BYTE_CR;
            2: return BYTE_LF;
            3: return 8'h09;
            default: return 8'($urandom_range(8'h7E, 8'h21));
        endcase
    endfunction

    // Units that hit one of the tests on their own.
    function automatic logic [15:0] telling_unit();
        case ($urandom_range(13))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return UNIT_BOM_SWAPPED;
            3: return UNIT_BOM;
            4: return UNIT_IDEO_SPACE;
            5: return 16'h0900;
            6: return 16'h0A00;
            7: return 16'h0D00;
            8: return 16'h2000;
            9: return UNIT_CRLF_PACKED;
            10: return 16'h0D0A;
            11: return {BYTE_EOF, text_byte()};
            12: return {BYTE_CR, BYTE_LF};
            default: return {BYTE_LF, BYTE_CR};
        endcase
    endfunction

    function automatic logic [15:0] make_unit(input text_kind_e kind);
        case (kind)
            TEXT_ASCII: return {8'h00, text_byte()};
            TEXT_SWAPPED: return {text_byte(), 8'h00};
            TEXT_WIDE: return {8'($urandom_range(8'h9F, 8'h4E)), 8'($urandom())};
            TEXT_SPECIAL: return telling_unit();
            TEXT_MIXED: begin
                case ($urandom_range(3))
                    0: return {8'h00, text_byte()};
                    1: return telling_unit();
                    2: return {text_byte(), 8'h00};
                    default: return 16'($urandom());
                endcase
            end
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_buffer(input int units, input int len, input text_kind_e kind,
                              input logic mgiven, input logic [15:0] mask, input logic drain);
        logic [15:0] u;
        int word_len;
        for (int i = 0; i < units; i++) begin
            u = make_unit(kind);
            if (i == 0 && $urandom_range(5) == 0) u = UNIT_BOM;
            else if (i == 0 && $urandom_range(9) == 0) u = UNIT_BOM_SWAPPED;
            // Give the tail-drop rule plenty of chances.
            if (i == units - 1 && $urandom_range(2) == 0) u[15:8] = 8'h00;
            word_len = len;
            if (kind == TEXT_NOISE && $urandom_range(3) == 0)
                word_len = ($urandom_range(1) == 0) ? $urandom_range(1) : $urandom_range(1023);
            push_word(u, i == units - 1, word_len, mgiven, mask, drain && i == 0);
        end
    endtask

    task automatic add_random_buffer();
        int units;
        int len;
        int pick;
        text_kind_e kind;
        pick = $urandom_range(99);
        units = (pick < 2) ? $urandom_range(280, 120) : $urandom_range(16, 1);
        pick = $urandom_range(99);
        if (pick < 50) len = 2 * units;
        else if (pick < 70) len = 2 * units - 1;
        else if (pick < 85) len = $urandom_range(1023);
        else len = 2 * $urandom_range(256, 1);
        if (len > 1023) len = 1022 + (len & 1);
        // Mostly well-formed text of one kind; the rest special, mixed, random or noisy.
        pick = $urandom_range(99);
        if (pick < 25) kind = TEXT_ASCII;
        else if (pick < 40) kind = TEXT_SWAPPED;
        else if (pick < 55) kind = TEXT_WIDE;
        else if (pick < 65) kind = TEXT_SPECIAL;
        else if (pick < 80) kind = TEXT_MIXED;
        else if (pick < 90) kind = TEXT_RANDOM;
        else kind = TEXT_NOISE;
        add_buffer(units, len, kind, $urandom_range(3) == 0, 16'($urandom()),
                   $urandom_range(99) < 3);
    endtask

    task automatic build_stimulus();
        // Too short: length zero and length one.
        push_word(16'hFFFF, 1'b1, 0, 1'b0, 16'h0000, 1'b0);
        push_word(16'h4142, 1'b1, 1, 1'b1, 16'hFFFF, 1'b0);
        // Single unit that looks like ASCII, then two single units that do not.
        push_word(16'h0041, 1'b1, 2, 1'b0, 16'h0000, 1'b0);
        push_word(16'h0000, 1'b1, 2, 1'b0, 16'h0000, 1'b0);
        push_word(16'h4100, 1'b1, 2, 1'b0, 16'h0000, 1'b0);
        // Longest odd length, everything let through the mask.
        push_word(16'hFFFF, 1'b1, 1023, 1'b1, 16'hFFFF, 1'b0);
        // Only a droppable tail arrives, so nothing is scanned at all.
        push_word(16'h0041, 1'b1, 6, 1'b0, 16'h0000, 1'b0);
        // Byte-order mark, sent once the block has gone quiet.
        push_word(UNIT_BOM, 1'b0, 6, 1'b0, 16'h0000, 1'b1);
        push_word(16'h0048, 1'b0, 6, 1'b0, 16'h0000, 1'b0);
        push_word(16'h0069, 1'b1, 6, 1'b0, 16'h0000, 1'b0);
        // Swapped mark with byte-swapped text, odd length.
        push_word(UNIT_BOM_SWAPPED, 1'b0, 5, 1'b0, 16'h0000, 1'b0);
        push_word(16'h4800, 1'b0, 5, 1'b0, 16'h0000, 1'b0);
        push_word(16'h6900, 1'b1, 5, 1'b0, 16'h0000, 1'b0);
        // Controls, reversed controls, a packed CR/LF and an EOF high byte last.
        push_word(UNIT_IDEO_SPACE, 1'b0, 8, 1'b0, 16'h0000, 1'b0);
        push_word(16'h0900, 1'b0, 8, 1'b0, 16'h0000, 1'b0);
        push_word(UNIT_CRLF_PACKED, 1'b0, 8, 1'b0, 16'h0000, 1'b0);
        push_word({BYTE_EOF, 8'h41}, 1'b1, 8, 1'b0, 16'h0000, 1'b0);
        // CR at the top of one unit, LF at the bottom of the next.
        push_word({BYTE_CR, 8'h41}, 1'b0, 4, 1'b0, 16'h0000, 1'b0);
        push_word({8'h41, BYTE_LF}, 1'b1, 4, 1'b0, 16'h0000, 1'b0);
        // A unit that is ignored for its short length, then a short buffer.
        push_word(16'h1234, 1'b0, 0, 1'b1, 16'h0000, 1'b0);
        push_word(16'h5678, 1'b1, 0, 1'b1, 16'h0000, 1'b0);
        // Masked flags with a droppable tail.
        push_word(16'h0020, 1'b0, 4, 1'b1, 16'h1234, 1'b0);
        push_word(16'h00FF, 1'b1, 4, 1'b1, 16'h1234, 1'b0);

        // More units than the block is sized for.
        add_buffer(258, 516, TEXT_RANDOM, 1'b0, 16'h0000, 1'b0);

        while (words_to_send.size() < WORD_TARGET)
            add_random_buffer();
    endtask

    // ---------------------------------------------------------------------
    // Driver: offers the next word whenever the channel is free, unless it
    // decides to idle, or the word asks for the block to drain first.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_unit <= '0;
            s_last_unit <= 1'b0;
            s_buffer_length <= '0;
            s_mask_given <= 1'b0;
            s_mask_in <= '0;
        end else begin
            if (s_valid && s_ready) begin
                predict(on_wire);
                words_sent++;
            end
            steady <= words_sent >= STEADY_FROM && words_sent < STEADY_TO;
            if (!s_valid || s_ready) begin
                if (words_to_send.size() != 0 &&
                    !(words_to_send[0].drain && pending_verdicts.size() != 0) &&
                    (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                    on_wire = words_to_send.pop_front();
                    s_valid <= 1'b1;
                    s_unit <= on_wire.unit;
                    s_last_unit <= on_wire.last;
                    s_buffer_length <= on_wire.len;
                    s_mask_given <= on_wire.mgiven;
                    s_mask_in <= on_wire.mask;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: compares every result word with the oldest prediction and
    // stalls the result channel at random.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: result with none expected, got flags %h verdict %b",
                             $time, m_flags_out, m_is_unicode);
                    error_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    verdicts_checked++;
                    if (m_flags_out !== want.flags) begin
                        $display("%0t: flags expected %h, got %h",
                                 $time, want.flags, m_flags_out);
                        error_count++;
                    end
                    if (m_is_unicode !== want.is_text) begin
                        $display("%0t: verdict expected %b, got %b",
                                 $time, want.is_text, m_is_unicode);
                        error_count++;
                    end
                end
            end
            m_ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words unsent, %0d results outstanding",
                     CYCLE_LIMIT, words_to_send.size(), pending_verdicts.size());
            $display("utf16_text_classifier: mismatch");
            $finish;
        end
    end

    initial begin
        clear_stats();
        build_stimulus();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Every word sent and every result back, then a quiet settling period so
        // that a spurious extra result would still be caught.
        while (words_to_send.size() != 0 || s_valid || pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d words and checked %0d verdicts: %0d short or single-unit rejects,",
                 words_sent, verdicts_checked, early_rejects);
        $display("%0d judged as text, the rest covering signatures, masks and noisy lengths.",
                 judged_text);
        if (error_count == 0) begin
            $display("utf16_text_classifier: match");
        end else begin
            $display("utf16_text_classifier: mismatch");
        end
        $finish;
    end

endmodule
